@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker module of the matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ISM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ism_pkg.sv @@
// Shared types, operation codes and helpers of the substring matcher.
`timescale 1ns / 1ps

package ism_pkg;

  localparam int MAX_NEEDLE_DEF = 64;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEXT   = 2'd2;
  localparam logic [1:0] OP_END    = 2'd3;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef struct packed {
    logic text_en;
    logic restart;
    logic append;
  } cell_ctrl_t;

  // One result; match sits in the lowest bit.
  typedef struct packed {
    logic needle_too_long;
    logic match;
  } result_t;

  // ASCII upper-case letters map to lower case, everything else is unchanged.
  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/ism_cell.sv @@
// One position of the pattern: its byte and its bit of the partial match vector.
`timescale 1ns / 1ps

module ism_cell #(
  parameter int LEN_W = 7,
  parameter int IDX   = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ism_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]         char_in,
  input  logic [LEN_W-1:0]   len,
  input  logic               prev_match,
  output logic               match_out,
  output logic               hit
);

  logic [7:0] pat_r;
  logic       match_r;
  logic       match_nxt;
  logic       active;
  logic       step_bit;

  assign active   = LEN_W'(IDX) < len;
  assign step_bit = prev_match & active & (pat_r == char_in);

  always_comb begin
    match_nxt = match_r;
    if (ctrl.restart) begin
      match_nxt = 1'b0;
    end else if (ctrl.text_en) begin
      match_nxt = step_bit;
    end
  end

  // A hit is a full match ending at this byte, seen only by the last pattern cell.
  assign hit       = ctrl.text_en & step_bit & (len == LEN_W'(IDX + 1));
  assign match_out = match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.append && len == LEN_W'(IDX)) begin
      pat_r <= char_in;
    end
  end

endmodule

@@ hw/rtl/ism_out_stage.sv @@
// Output register with a skid entry for the result channel.
`timescale 1ns / 1ps

module ism_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ism_pkg::result_t  push_data,
  input  logic              pop_ready,
  output logic              out_valid,
  output ism_pkg::result_t  out_data,
  output logic              space
);

  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             skid_valid_r;
  logic             skid_valid_nxt;
  ism_pkg::result_t out_data_r;
  ism_pkg::result_t out_data_nxt;
  ism_pkg::result_t skid_data_r;
  ism_pkg::result_t skid_data_nxt;
  logic             pop;

  assign pop = out_valid_r & pop_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign space     = ~skid_valid_r;

endmodule

@@ hw/rtl/icase_substring_matcher.sv @@
// Top level of the case-insensitive substring matcher.
`timescale 1ns / 1ps
// Usage: the input channel carries one operation per transfer, its code on
// in_tuser (clear, append pattern byte, text byte, end of text) and its byte
// on in_tdata. Letters are folded to lower case before they are stored or
// compared. Appended bytes fill a row of cells, one cell per pattern position;
// bytes beyond MAX_NEEDLE are dropped and flagged. Each text byte is broadcast
// to all cells and every cell but the first takes its neighbour's partial
// match bit, so every pattern position is compared with the byte in parallel.
// Throughput: one transfer per cycle for every operation while in_tready is
// high, set by the single register stage of the cell chain.
// Result: an end-of-text transfer places its result in the output register,
// or in the skid entry while the receiver stalls; no other operation does.
// Reset clears the pattern length, the flags, the match vector and the output
// stage; no clearing pass is needed. While the receiver stalls, one further
// result is held in a skid entry and input transfers continue; in_tready
// falls only once that entry is occupied too.
module icase_substring_matcher #(
  parameter int MAX_NEEDLE = ism_pkg::MAX_NEEDLE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [1:0] in_tuser,   // [1:0] operation
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] match, [1] needle_too_long, [7:2] zero
);

  localparam int LEN_W = $clog2(MAX_NEEDLE + 1);

  logic                 accept;
  logic [7:0]           char_f;
  ism_pkg::cell_ctrl_t  ctrl;
  logic [LEN_W-1:0]     len_r;
  logic [LEN_W-1:0]     len_nxt;
  logic                 overflow_r;
  logic                 overflow_nxt;
  logic                 found_r;
  logic                 found_nxt;
  logic                 full;
  logic [MAX_NEEDLE-1:0] match_bits;
  logic [MAX_NEEDLE-1:0] hits;
  logic                 push;
  ism_pkg::result_t     result;
  ism_pkg::result_t     out_res;

  assign accept = in_tvalid & in_tready;
  assign char_f = ism_pkg::fold_byte(in_tdata);
  assign full   = len_r == LEN_W'(MAX_NEEDLE);

  assign ctrl.text_en = accept & (in_tuser == ism_pkg::OP_TEXT);
  assign ctrl.restart = accept & (in_tuser != ism_pkg::OP_TEXT);
  assign ctrl.append  = accept & (in_tuser == ism_pkg::OP_APPEND);

  genvar g;
  generate
    for (g = 0; g < MAX_NEEDLE; g++) begin : g_cell
      logic prev;
      if (g == 0) begin : g_first
        // A new partial match may start at every text byte.
        assign prev = 1'b1;
      end else begin : g_rest
        assign prev = match_bits[g-1];
      end
      ism_cell #(
        .LEN_W (LEN_W),
        .IDX   (g)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .char_in    (char_f),
        .len        (len_r),
        .prev_match (prev),
        .match_out  (match_bits[g]),
        .hit        (hits[g])
      );
    end
  endgenerate

  always_comb begin
    len_nxt      = len_r;
    overflow_nxt = overflow_r;
    found_nxt    = found_r;
    if (accept) begin
      case (in_tuser)
        ism_pkg::OP_CLEAR: begin
          len_nxt      = '0;
          overflow_nxt = 1'b0;
          found_nxt    = 1'b0;
        end
        ism_pkg::OP_APPEND: begin
          found_nxt = 1'b0;
          if (full) begin
            overflow_nxt = 1'b1;
          end else begin
            len_nxt = len_r + 1'b1;
          end
        end
        ism_pkg::OP_TEXT: begin
          if (|hits) begin
            found_nxt = 1'b1;
          end
        end
        default: begin
          found_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r      <= '0;
      overflow_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      len_r      <= len_nxt;
      overflow_r <= overflow_nxt;
      found_r    <= found_nxt;
    end
  end

  assign push                   = accept & (in_tuser == ism_pkg::OP_END);
  assign result.match           = (len_r == '0) | found_r;
  assign result.needle_too_long = overflow_r;

  ism_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (result),
    .pop_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_res),
    .space     (in_tready)
  );

  assign out_tdata = {6'b0, out_res};

endmodule

@@ hw/rtl/ism_checker.sv @@
// Port-level checks of the substring matcher, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ism_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [1:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  logic end_xfer;

  assign end_xfer = in_tvalid & in_tready & (in_tuser == ism_pkg::OP_END);

  // A stalled result must not change or vanish.
  `ISM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // A fresh result appears only after an end-of-text transfer.
  `ISM_ASSERT_SAME(a_out_cause, $rose(out_tvalid), $past(end_xfer), "result without end of text")

  // The input side backs up only while a result is waiting.
  `ISM_ASSERT_SAME(a_ready_cause, !in_tready, out_tvalid, "input stalled with empty output")

  // Padding bits of a result stay zero.
  `ISM_ASSERT_SAME(a_out_pad, out_tvalid, out_tdata[7:2] == 6'b0, "non-zero result padding")

endmodule

bind icase_substring_matcher ism_checker u_ism_checker (.*);

@@ test/icase_substring_matcher_test.sv @@
// Self-checking stream testbench for the case-insensitive substring matcher.
`timescale 1ns / 1ps

module icase_substring_matcher_test;

  localparam int NEEDLE_CAP   = ism_pkg::MAX_NEEDLE_DEF;
  localparam int RAND_ITEMS   = 1350;
  localparam int QUIET_TAIL   = 150;
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 1000;
  localparam int NUM_ROWS     = 27;

  // One directed row; exp is only used where typed is set.
  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       data;
    logic [6:0]       reps;
    logic             typed;
    ism_pkg::result_t exp;   // {needle_too_long, match}
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    '{ism_pkg::OP_END,    8'h00, 7'd1,  1'b1, 2'b01},  // empty pattern straight after reset
    '{ism_pkg::OP_TEXT,   8'hFF, 7'd1,  1'b0, 2'b00},
    '{ism_pkg::OP_END,    8'h00, 7'd1,  1'b1, 2'b01},  // text leaves an empty pattern matching
    '{ism_pkg::OP_APPEND, 8'h41, 7'd1,  1'b0, 2'b00},
    '{ism_pkg::OP_APPEND, 8'h00, 7'd1,  1'b0, 2'b00},  // zero byte inside the pattern
    '{ism_pkg::OP_TEXT,   8'h61, 7'd1,  1'b0, 2'b00},
    '{ism_pkg::OP_TEXT,   8'h00, 7'd1,  1'b0, 2'b00},
    '{ism_pkg::OP_END,    8'hAA, 7'd1,  1'b0, 2'b00},
    '{ism_pkg::OP_TEXT,   8'h61, 7'd1,  1'b0, 2'b00},
    '{ism_pkg::OP_APPEND, 8'h5A, 7'd1,  1'b0, 2'b00},  // append in the middle of a text
    '{ism_pkg::OP_TEXT,   8'h41, 7'd1,  1'b0, 2'b00},
    '{ism_pkg::OP_TEXT,   8'h00, 7'd1,  1'b0, 2'b00},
    '{ism_pkg::OP_TEXT,   8'h7A, 7'd1,  1'b0, 2'b00},
    '{ism_pkg::OP_END,    8'h00, 7'd1,  1'b0, 2'b00},
    '{ism_pkg::OP_CLEAR,  8'h55, 7'd1,  1'b0, 2'b00},
    '{ism_pkg::OP_APPEND, 8'hFF, 7'd3,  1'b0, 2'b00},
    '{ism_pkg::OP_TEXT,   8'hFF, 7'd2,  1'b0, 2'b00},
    '{ism_pkg::OP_END,    8'h00, 7'd1,  1'b1, 2'b00},  // pattern longer than the text
    '{ism_pkg::OP_CLEAR,  8'h00, 7'd1,  1'b0, 2'b00},
    '{ism_pkg::OP_APPEND, 8'h5B, 7'd65, 1'b0, 2'b00},  // one byte beyond a full store
    '{ism_pkg::OP_END,    8'h00, 7'd1,  1'b1, 2'b10},
    '{ism_pkg::OP_TEXT,   8'h5B, 7'd64, 1'b0, 2'b00},
    '{ism_pkg::OP_END,    8'h00, 7'd1,  1'b0, 2'b00},
    '{ism_pkg::OP_APPEND, 8'h40, 7'd1,  1'b0, 2'b00},
    '{ism_pkg::OP_END,    8'h00, 7'd1,  1'b1, 2'b10},
    '{ism_pkg::OP_CLEAR,  8'hFF, 7'd1,  1'b0, 2'b00},
    '{ism_pkg::OP_END,    8'h00, 7'd1,  1'b1, 2'b01}   // clear also drops the overflow flag
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] data_byte
  logic [1:0] in_tuser = 2'd0;    // [1:0] operation
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [0] match, [1] needle_too_long, [7:2] zero

  // Predictor state.
  logic [7:0]            needle_mem [NEEDLE_CAP];
  int                    needle_len = 0;
  logic [NEEDLE_CAP-1:0] partial_bits = '0;
  logic                  hit_seen = 1'b0;
  logic                  needle_dropped = 1'b0;

  ism_pkg::result_t expected_results [$];
  ism_pkg::result_t oldest_result;
  int      mismatches = 0;
  int      items_sent = 0;
  int      quiet_cycles = 0;
  bit      idle_on = 1'b1;

  icase_substring_matcher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] lower_ascii(input logic [7:0] b);
    if (b inside {[8'h41:8'h5A]}) begin
      return b + 8'h20;
    end
    return b;
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] b);
    if ((b inside {[8'h41:8'h5A], [8'h61:8'h7A]}) && $urandom_range(0, 1) == 1) begin
      return b ^ 8'h20;
    end
    return b;
  endfunction

  // Advances the predicted matcher by one operation; returns 1 when it yields a result.
  function automatic bit track_op(input logic [1:0] op, input logic [7:0] raw,
                                  output ism_pkg::result_t res);
    logic [7:0] c;
    c = lower_ascii(raw);
    res = '0;
    case (op)
      ism_pkg::OP_CLEAR: begin
        needle_len = 0;
        needle_dropped = 1'b0;
        partial_bits = '0;
        hit_seen = 1'b0;
      end
      ism_pkg::OP_APPEND: begin
        if (needle_len < NEEDLE_CAP) begin
          needle_mem[needle_len] = c;
          needle_len++;
        end else begin
          needle_dropped = 1'b1;
        end
        partial_bits = '0;
        hit_seen = 1'b0;
      end
      ism_pkg::OP_TEXT: begin
        if (needle_len != 0) begin
          partial_bits = {partial_bits[NEEDLE_CAP-2:0], 1'b1};
          for (int i = 0; i < NEEDLE_CAP; i++) begin
            if (i >= needle_len || needle_mem[i] != c) begin
              partial_bits[i] = 1'b0;
            end
          end
          if (partial_bits[needle_len-1]) begin
            hit_seen = 1'b1;
          end
        end
      end
      default: begin
        res.match = (needle_len == 0) || hit_seen;
        res.needle_too_long = needle_dropped;
        partial_bits = '0;
        hit_seen = 1'b0;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // Offers one item, waits for its transfer and records what it should produce.
  task automatic send_item(input logic [1:0] op, input logic [7:0] b,
                           input bit typed = 1'b0, input ism_pkg::result_t typed_res = '0);
    ism_pkg::result_t predicted;
    bit      yields;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    yields = track_op(op, b, predicted);
    if (yields) begin
      expected_results.push_back(typed ? typed_res : predicted);
    end
    items_sent++;
  endtask

  function automatic logic [7:0] pick_needle_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return flip_case(8'h61 + 8'($urandom_range(0, 2)));
    end else if (r < 8) begin
      case ($urandom_range(0, 5))
        0: return 8'h40;
        1: return 8'h5B;
        2: return 8'h60;
        3: return 8'h7B;
        4: return 8'h00;
        default: return 8'hFF;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // A pattern load followed by a few texts, some of which carry the pattern.
  task automatic play_session();
    logic [7:0] pat [$];
    int         plen;
    int         tlen;
    int         plant_at;
    int         k;
    logic [7:0] b;
    if ($urandom_range(0, 9) != 0) begin
      send_item(ism_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
    end
    k = $urandom_range(0, 19);
    if (k == 0) begin
      plen = 0;
    end else if (k < 16) begin
      plen = $urandom_range(1, 6);
    end else if (k < 19) begin
      plen = $urandom_range(7, 40);
    end else begin
      plen = $urandom_range(60, 70);
    end
    repeat (plen) begin
      b = pick_needle_byte();
      pat.push_back(b);
      send_item(ism_pkg::OP_APPEND, b);
    end
    repeat ($urandom_range(1, 4)) begin
      tlen = $urandom_range(0, 24);
      plant_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, tlen) : -1;
      for (int j = 0; j <= tlen; j++) begin
        if (j == plant_at) begin
          foreach (pat[m]) begin
            if (m < NEEDLE_CAP) begin
              send_item(ism_pkg::OP_TEXT, flip_case(pat[m]));
            end
          end
        end
        if (j == tlen) begin
          break;
        end
        if ($urandom_range(0, 29) == 0) begin
          send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end else if (pat.size() != 0 && $urandom_range(0, 9) < 6) begin
          send_item(ism_pkg::OP_TEXT, flip_case(pat[$urandom_range(0, pat.size() - 1)]));
        end else if ($urandom_range(0, 1) == 0) begin
          send_item(ism_pkg::OP_TEXT, pick_needle_byte());
        end else begin
          send_item(ism_pkg::OP_TEXT, 8'($urandom_range(0, 255)));
        end
      end
      send_item(ism_pkg::OP_END, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIR_ROWS[r]) begin
      repeat (DIR_ROWS[r].reps) begin
        send_item(DIR_ROWS[r].op, DIR_ROWS[r].data, DIR_ROWS[r].typed, DIR_ROWS[r].exp);
      end
    end
    // The random sessions top the directed rows up to the total item count.
    while (items_sent < RAND_ITEMS) begin
      idle_on = (items_sent < RAND_ITEMS - QUIET_TAIL);
      play_session();
    end
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("icase_substring_matcher regression: pass");
    end else begin
      $display("icase_substring_matcher regression: fail");
    end
    $finish;
  end

  // Receiver: ready in runs, with stall bursts while idling is allowed.
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: out_tdata %02h", out_tdata);
        mismatches++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_tdata[0] !== oldest_result.match) begin
          $error("match: expected %0b, actual %0b", oldest_result.match, out_tdata[0]);
          mismatches++;
        end
        if (out_tdata[1] !== oldest_result.needle_too_long) begin
          $error("needle_too_long: expected %0b, actual %0b",
                 oldest_result.needle_too_long, out_tdata[1]);
          mismatches++;
        end
        if (out_tdata[7:2] !== 6'd0) begin
          $error("padding: expected 00, actual %02h", out_tdata[7:2]);
          mismatches++;
        end
      end
    end
  end

  // The run is stuck once neither channel has seen a transfer for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("icase_substring_matcher regression: fail");
        $finish;
      end
    end
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ism_pkg.sv
hw/rtl/ism_cell.sv
hw/rtl/ism_out_stage.sv
hw/rtl/icase_substring_matcher.sv
hw/rtl/ism_checker.sv
test/icase_substring_matcher_test.sv
